### hdl/lavm_pkg.sv
// Shared types, widths and state encodings for the look-at view matrix block.
// No dependencies; used by every other file in hdl.
`default_nettype none

package lavm_pkg;

    localparam int WORD_W     = 32;   // Q16.16 port word
    localparam int UNIT_W     = 18;   // normalised component, |v| <= 1.0
    localparam int ACC_W      = 64;   // exact Q32.32 sums and products
    localparam int QDEPTH_DEF = 2;

    localparam int SQR_STEPS   = 3;
    localparam int SQRT_STEPS  = 32;
    localparam int DIV_STEPS   = 17;
    localparam int CROSS_STEPS = 6;
    localparam int DOT_STEPS   = 9;
    localparam int ROW_LAST    = 3;

    typedef logic signed [WORD_W-1:0] word_t;
    typedef logic signed [UNIT_W-1:0] unit_t;
    typedef logic signed [ACC_W-1:0]  acc_t;

    typedef struct packed {
        logic [2:0][WORD_W-1:0] pos;
        logic [2:0][WORD_W-1:0] dir;
        logic [2:0][WORD_W-1:0] up;
        logic                   dir_zero;
    } item_t;

    typedef struct packed {
        logic done;
        logic ok;
    } norm_stat_t;

    typedef enum logic [2:0] {
        N_IDLE,
        N_SHIFT,
        N_SQR,
        N_SQRT,
        N_LOAD,
        N_DIV
    } norm_state_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_NZ_GO,
        B_NZ_WAIT,
        B_UZ,
        B_NX_GO,
        B_NX_WAIT,
        B_ZX,
        B_DOT,
        B_EMIT
    } back_state_t;

endpackage

`default_nettype wire

### hdl/lavm_front.sv
// Front end: takes request transfers, flags a zero look vector, queues items.
// Depends on lavm_pkg.
`default_nettype none

module lavm_front #(
    parameter int DEPTH = lavm_pkg::QDEPTH_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [31:0]           pos_x,
    input  wire logic [31:0]           pos_y,
    input  wire logic [31:0]           pos_z,
    input  wire logic [31:0]           dir_x,
    input  wire logic [31:0]           dir_y,
    input  wire logic [31:0]           dir_z,
    input  wire logic [31:0]           up_x,
    input  wire logic [31:0]           up_y,
    input  wire logic [31:0]           up_z,
    input  wire logic                  pop,
    output logic                       q_valid,
    output lavm_pkg::item_t            item
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    lavm_pkg::item_t entry_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    lavm_pkg::item_t in_item;
    logic            push;
    logic            pull;

    always_comb
    begin
        in_item.pos      = {pos_z, pos_y, pos_x};
        in_item.dir      = {dir_z, dir_y, dir_x};
        in_item.up       = {up_z, up_y, up_x};
        in_item.dir_zero = (dir_x == '0) && (dir_y == '0) && (dir_z == '0);
    end

    assign busy    = (count_reg == CW'(DEPTH));
    assign q_valid = (count_reg != '0);
    assign item    = entry_reg[rd_ptr_reg];
    assign push    = start && !busy;
    assign pull    = pop && q_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pull)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pull)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pull && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

`default_nettype wire

### hdl/lavm_norm.sv
// Iterative vector normaliser: block shift, sum of squares, integer square
// root, then one restoring division per component. Depends on lavm_pkg.
`default_nettype none

module lavm_norm (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    input  wire logic [2:0][63:0]        vin,
    output logic [2:0][17:0]             vout,
    output lavm_pkg::norm_stat_t         stat
);

    lavm_pkg::norm_state_t state_reg, state_next;
    logic [2:0][63:0]      mag_reg;
    logic [2:0]            neg_reg;
    logic [4:0]            cnt_reg;
    logic [1:0]            ci_reg;
    logic [61:0]           prod_reg;
    logic [63:0]           sum_reg;
    logic [63:0]           res_reg;
    logic [63:0]           bit_reg;
    logic [32:0]           rem_reg;
    logic [16:0]           qsh_reg;
    logic [2:0][17:0]      vout_reg;
    lavm_pkg::norm_stat_t  stat_reg;

    logic [63:0] or_all;
    logic        is_zero;
    logic        too_big;
    logic        too_small;
    logic [64:0] trial;
    logic        take;
    logic [47:0] num;
    logic [32:0] dtrial;
    logic        ge;
    logic [16:0] quot;
    logic        sqr_end;
    logic        sqrt_end;
    logic        div_end;
    lavm_pkg::norm_stat_t stat_c;

    always_comb
    begin
        or_all    = mag_reg[0] | mag_reg[1] | mag_reg[2];
        is_zero   = (or_all == '0);
        too_big   = |or_all[63:31];
        too_small = !or_all[30];
        trial     = {1'b0, res_reg} + {1'b0, bit_reg};
        take      = ({1'b0, sum_reg} >= trial);
        num       = {1'b0, mag_reg[ci_reg][30:0], 16'b0} + {17'b0, res_reg[31:1]};
        dtrial    = {rem_reg[31:0], qsh_reg[16]};
        ge        = (dtrial >= {1'b0, res_reg[31:0]});
        quot      = {qsh_reg[15:0], ge};
        sqr_end   = (cnt_reg == 5'(lavm_pkg::SQR_STEPS));
        sqrt_end  = (cnt_reg == 5'(lavm_pkg::SQRT_STEPS - 1));
        div_end   = (cnt_reg == 5'(lavm_pkg::DIV_STEPS - 1));
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lavm_pkg::N_IDLE:
            begin
                if (start)
                begin
                    state_next = lavm_pkg::N_SHIFT;
                end
            end
            lavm_pkg::N_SHIFT:
            begin
                if (is_zero)
                begin
                    state_next = lavm_pkg::N_IDLE;
                end
                else if (!too_big && !too_small)
                begin
                    state_next = lavm_pkg::N_SQR;
                end
            end
            lavm_pkg::N_SQR:
            begin
                if (sqr_end)
                begin
                    state_next = lavm_pkg::N_SQRT;
                end
            end
            lavm_pkg::N_SQRT:
            begin
                if (sqrt_end)
                begin
                    state_next = lavm_pkg::N_LOAD;
                end
            end
            lavm_pkg::N_LOAD:
            begin
                state_next = lavm_pkg::N_DIV;
            end
            lavm_pkg::N_DIV:
            begin
                if (div_end)
                begin
                    state_next = (ci_reg == 2'd2) ? lavm_pkg::N_IDLE : lavm_pkg::N_LOAD;
                end
            end
            default:
            begin
                state_next = lavm_pkg::N_IDLE;
            end
        endcase
    end

    // status outputs
    always_comb
    begin
        stat_c.done = 1'b0;
        stat_c.ok   = 1'b1;
        case (state_reg)
            lavm_pkg::N_SHIFT:
            begin
                if (is_zero)
                begin
                    stat_c.done = 1'b1;
                    stat_c.ok   = 1'b0;
                end
            end
            lavm_pkg::N_DIV:
            begin
                stat_c.done = div_end && (ci_reg == 2'd2);
            end
            default:
            begin
                stat_c.done = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lavm_pkg::N_IDLE;
            stat_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            stat_reg  <= stat_c;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            lavm_pkg::N_IDLE:
            begin
                if (start)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        mag_reg[i] <= vin[i][63] ? 64'(-vin[i]) : vin[i];
                        neg_reg[i] <= vin[i][63];
                    end
                end
            end
            lavm_pkg::N_SHIFT:
            begin
                if (too_big)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        mag_reg[i] <= mag_reg[i] >> 1;
                    end
                end
                else if (too_small && !is_zero)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        mag_reg[i] <= mag_reg[i] << 1;
                    end
                end
                cnt_reg <= '0;
                sum_reg <= '0;
            end
            lavm_pkg::N_SQR:
            begin
                // square issued one cycle, summed the next
                if (!sqr_end)
                begin
                    prod_reg <= mag_reg[cnt_reg[1:0]][30:0] * mag_reg[cnt_reg[1:0]][30:0];
                end
                if (cnt_reg != '0)
                begin
                    sum_reg <= sum_reg + {2'b0, prod_reg};
                end
                if (sqr_end)
                begin
                    cnt_reg <= '0;
                    res_reg <= '0;
                    bit_reg <= 64'h4000_0000_0000_0000;
                end
                else
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
            lavm_pkg::N_SQRT:
            begin
                if (take)
                begin
                    sum_reg <= sum_reg - trial[63:0];
                    res_reg <= (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_reg <= res_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
                cnt_reg <= sqrt_end ? '0 : cnt_reg + 1'b1;
                ci_reg  <= '0;
            end
            lavm_pkg::N_LOAD:
            begin
                // quotient fits in 17 bits, so the top of the dividend is already below L
                rem_reg <= {2'b0, num[47:17]};
                qsh_reg <= num[16:0];
                cnt_reg <= '0;
            end
            lavm_pkg::N_DIV:
            begin
                rem_reg <= ge ? dtrial - {1'b0, res_reg[31:0]} : dtrial;
                qsh_reg <= quot;
                cnt_reg <= cnt_reg + 1'b1;
                if (div_end)
                begin
                    vout_reg[ci_reg] <= neg_reg[ci_reg] ? 18'(-{1'b0, quot}) : {1'b0, quot};
                    ci_reg           <= ci_reg + 1'b1;
                end
            end
            default:
            begin
                cnt_reg <= '0;
            end
        endcase
    end

    assign vout = vout_reg;
    assign stat = stat_reg;

endmodule

`default_nettype wire

### hdl/lavm_back.sv
// Back end: sequences the normaliser and a shared multiply-accumulate through
// z, x, y and the translation row, then emits the four rows. Depends on lavm_pkg.
`default_nettype none

module lavm_back (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  q_valid,
    input  wire lavm_pkg::item_t       item,
    output logic                       pop,
    output logic                       norm_start,
    output logic [2:0][63:0]           norm_vin,
    input  wire logic [2:0][17:0]      norm_vout,
    input  wire lavm_pkg::norm_stat_t  norm_stat,
    output logic                       valid,
    output logic [1:0]                 row_index,
    output logic [31:0]                col_first,
    output logic [31:0]                col_second,
    output logic [31:0]                col_third,
    output logic                       degenerate,
    output logic                       last_row
);

    lavm_pkg::back_state_t state_reg, state_next;
    lavm_pkg::item_t       item_reg;
    logic [2:0][17:0]      z_reg, x_reg, y_reg;
    logic [2:0][31:0]      t_reg;
    logic                  bad_reg;
    logic [3:0]            cnt_reg;
    logic [2:0][63:0]      acc_reg;
    logic [2:0][63:0]      acc_next;
    logic signed [63:0]    prod_reg;
    logic [1:0]            pdest_reg;
    logic                  psub_reg;
    logic                  pvld_reg;
    logic [1:0]            row_reg;

    logic                  valid_reg;
    logic [1:0]            row_index_reg;
    logic [31:0]           col_first_reg, col_second_reg, col_third_reg;
    logic                  degenerate_reg, last_row_reg;

    logic                  issue;
    logic                  mac_end;
    logic [1:0]            ai, bi, dest;
    logic                  sub;
    logic [2:0][32:0]      va, vb;
    logic signed [32:0]    op_a, op_b;
    logic signed [65:0]    prod;
    logic [2:0][17:0]      y_rnd;
    logic [2:0][31:0]      t_sat;

    // round Q32.32 to Q16.16, half away from zero
    function automatic logic signed [63:0] rnd(input logic signed [63:0] v);
        logic [63:0] m;
        logic [63:0] r;
        m = v[63] ? 64'(-v) : v;
        r = (m + 64'h8000) >> 16;
        return v[63] ? $signed(64'(-r)) : $signed(r);
    endfunction

    function automatic logic [31:0] neg_sat(input logic signed [63:0] v);
        logic signed [63:0] n;
        n = -rnd(v);
        if (n > 64'sh0000_0000_7FFF_FFFF)
        begin
            return 32'h7FFF_FFFF;
        end
        else if (n < -64'sh0000_0000_8000_0000)
        begin
            return 32'h8000_0000;
        end
        return n[31:0];
    endfunction

    // operand selection for the shared multiplier
    always_comb
    begin
        ai   = 2'd0;
        bi   = 2'd0;
        dest = 2'd0;
        sub  = 1'b0;
        va   = '0;
        vb   = '0;
        if (state_reg == lavm_pkg::B_DOT)
        begin
            case (cnt_reg)
                4'd0: begin dest = 2'd0; ai = 2'd0; end
                4'd1: begin dest = 2'd0; ai = 2'd1; end
                4'd2: begin dest = 2'd0; ai = 2'd2; end
                4'd3: begin dest = 2'd1; ai = 2'd0; end
                4'd4: begin dest = 2'd1; ai = 2'd1; end
                4'd5: begin dest = 2'd1; ai = 2'd2; end
                4'd6: begin dest = 2'd2; ai = 2'd0; end
                4'd7: begin dest = 2'd2; ai = 2'd1; end
                4'd8: begin dest = 2'd2; ai = 2'd2; end
                default: begin dest = 2'd0; ai = 2'd0; end
            endcase
            bi = ai;
            for (int i = 0; i < 3; i++)
            begin
                vb[i] = {item_reg.pos[i][31], item_reg.pos[i]};
                case (dest)
                    2'd0:    va[i] = 33'($signed(x_reg[i]));
                    2'd1:    va[i] = 33'($signed(y_reg[i]));
                    default: va[i] = 33'($signed(z_reg[i]));
                endcase
            end
        end
        else
        begin
            // a x b: c0 = a1b2 - a2b1, c1 = a2b0 - a0b2, c2 = a0b1 - a1b0
            case (cnt_reg)
                4'd0: begin ai = 2'd1; bi = 2'd2; dest = 2'd0; sub = 1'b0; end
                4'd1: begin ai = 2'd2; bi = 2'd1; dest = 2'd0; sub = 1'b1; end
                4'd2: begin ai = 2'd2; bi = 2'd0; dest = 2'd1; sub = 1'b0; end
                4'd3: begin ai = 2'd0; bi = 2'd2; dest = 2'd1; sub = 1'b1; end
                4'd4: begin ai = 2'd0; bi = 2'd1; dest = 2'd2; sub = 1'b0; end
                4'd5: begin ai = 2'd1; bi = 2'd0; dest = 2'd2; sub = 1'b1; end
                default: begin ai = 2'd0; bi = 2'd0; dest = 2'd0; sub = 1'b0; end
            endcase
            for (int i = 0; i < 3; i++)
            begin
                if (state_reg == lavm_pkg::B_ZX)
                begin
                    va[i] = 33'($signed(z_reg[i]));
                    vb[i] = 33'($signed(x_reg[i]));
                end
                else
                begin
                    va[i] = {item_reg.up[i][31], item_reg.up[i]};
                    vb[i] = 33'($signed(z_reg[i]));
                end
            end
        end
        op_a = $signed(va[ai]);
        op_b = $signed(vb[bi]);
        prod = op_a * op_b;
    end

    always_comb
    begin
        acc_next = acc_reg;
        if (pvld_reg)
        begin
            acc_next[pdest_reg] = psub_reg ? acc_reg[pdest_reg] - prod_reg
                                           : acc_reg[pdest_reg] + prod_reg;
        end
        for (int i = 0; i < 3; i++)
        begin
            y_rnd[i] = 18'(rnd($signed(acc_next[i])));
            t_sat[i] = neg_sat($signed(acc_next[i]));
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lavm_pkg::B_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = item.dir_zero ? lavm_pkg::B_EMIT : lavm_pkg::B_NZ_GO;
                end
            end
            lavm_pkg::B_NZ_GO:   state_next = lavm_pkg::B_NZ_WAIT;
            lavm_pkg::B_NZ_WAIT:
            begin
                if (norm_stat.done)
                begin
                    state_next = norm_stat.ok ? lavm_pkg::B_UZ : lavm_pkg::B_EMIT;
                end
            end
            lavm_pkg::B_UZ:
            begin
                if (mac_end)
                begin
                    state_next = lavm_pkg::B_NX_GO;
                end
            end
            lavm_pkg::B_NX_GO:   state_next = lavm_pkg::B_NX_WAIT;
            lavm_pkg::B_NX_WAIT:
            begin
                if (norm_stat.done)
                begin
                    state_next = norm_stat.ok ? lavm_pkg::B_ZX : lavm_pkg::B_EMIT;
                end
            end
            lavm_pkg::B_ZX:
            begin
                if (mac_end)
                begin
                    state_next = lavm_pkg::B_DOT;
                end
            end
            lavm_pkg::B_DOT:
            begin
                if (mac_end)
                begin
                    state_next = lavm_pkg::B_EMIT;
                end
            end
            lavm_pkg::B_EMIT:
            begin
                if (row_reg == 2'(lavm_pkg::ROW_LAST))
                begin
                    state_next = lavm_pkg::B_IDLE;
                end
            end
            default:
            begin
                state_next = lavm_pkg::B_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb
    begin
        pop        = 1'b0;
        norm_start = 1'b0;
        norm_vin   = acc_reg;
        issue      = 1'b0;
        mac_end    = 1'b0;
        case (state_reg)
            lavm_pkg::B_IDLE:
            begin
                pop = q_valid;
            end
            lavm_pkg::B_NZ_GO:
            begin
                norm_start = 1'b1;
                for (int i = 0; i < 3; i++)
                begin
                    norm_vin[i] = {{32{item_reg.dir[i][31]}}, item_reg.dir[i]};
                end
            end
            lavm_pkg::B_NX_GO:
            begin
                norm_start = 1'b1;
            end
            lavm_pkg::B_UZ, lavm_pkg::B_ZX:
            begin
                issue   = (cnt_reg < 4'(lavm_pkg::CROSS_STEPS));
                mac_end = (cnt_reg == 4'(lavm_pkg::CROSS_STEPS));
            end
            lavm_pkg::B_DOT:
            begin
                issue   = (cnt_reg < 4'(lavm_pkg::DOT_STEPS));
                mac_end = (cnt_reg == 4'(lavm_pkg::DOT_STEPS));
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lavm_pkg::B_IDLE;
            pvld_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pvld_reg  <= issue;
            valid_reg <= (state_reg == lavm_pkg::B_EMIT);
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg  <= prod[63:0];
        pdest_reg <= dest;
        psub_reg  <= sub;
        case (state_reg)
            lavm_pkg::B_IDLE:
            begin
                if (q_valid)
                begin
                    item_reg <= item;
                    bad_reg  <= item.dir_zero;
                end
                row_reg <= '0;
            end
            lavm_pkg::B_NZ_WAIT:
            begin
                if (norm_stat.done)
                begin
                    z_reg   <= norm_vout;
                    bad_reg <= !norm_stat.ok;
                end
                cnt_reg <= '0;
                acc_reg <= '0;
            end
            lavm_pkg::B_NX_WAIT:
            begin
                if (norm_stat.done)
                begin
                    x_reg   <= norm_vout;
                    bad_reg <= !norm_stat.ok;
                end
                cnt_reg <= '0;
                acc_reg <= '0;
            end
            lavm_pkg::B_UZ, lavm_pkg::B_ZX, lavm_pkg::B_DOT:
            begin
                if (mac_end)
                begin
                    cnt_reg <= '0;
                    if (state_reg == lavm_pkg::B_ZX)
                    begin
                        y_reg   <= y_rnd;
                        acc_reg <= '0;
                    end
                    else
                    begin
                        acc_reg <= acc_next;
                    end
                    if (state_reg == lavm_pkg::B_DOT)
                    begin
                        t_reg <= t_sat;
                    end
                end
                else
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    acc_reg <= acc_next;
                end
            end
            lavm_pkg::B_EMIT:
            begin
                row_index_reg  <= row_reg;
                degenerate_reg <= bad_reg;
                last_row_reg   <= (row_reg == 2'(lavm_pkg::ROW_LAST));
                if (bad_reg)
                begin
                    col_first_reg  <= '0;
                    col_second_reg <= '0;
                    col_third_reg  <= '0;
                end
                else if (row_reg == 2'(lavm_pkg::ROW_LAST))
                begin
                    col_first_reg  <= t_reg[0];
                    col_second_reg <= t_reg[1];
                    col_third_reg  <= t_reg[2];
                end
                else
                begin
                    col_first_reg  <= 32'($signed(x_reg[row_reg]));
                    col_second_reg <= 32'($signed(y_reg[row_reg]));
                    col_third_reg  <= 32'($signed(z_reg[row_reg]));
                end
                row_reg <= row_reg + 1'b1;
            end
            default:
            begin
                cnt_reg <= '0;
            end
        endcase
    end

    assign valid      = valid_reg;
    assign row_index  = row_index_reg;
    assign col_first  = col_first_reg;
    assign col_second = col_second_reg;
    assign col_third  = col_third_reg;
    assign degenerate = degenerate_reg;
    assign last_row   = last_row_reg;

endmodule

`default_nettype wire

### hdl/look_at_view_matrix.sv
// Look-at view matrix, Q16.16: four row transfers per request, one per cycle.
// A request waits in the queue while the back end works on an earlier one;
// the pace is set by the iterative normaliser (32-step square root, three
// 17-step divisions). With the default QDEPTH, two requests can queue.
// rst_n clears the queue and sequencers at once; the receiver cannot stall.
`default_nettype none

module look_at_view_matrix #(
    parameter int QDEPTH = lavm_pkg::QDEPTH_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [31:0] pos_x,
    input  wire logic [31:0] pos_y,
    input  wire logic [31:0] pos_z,
    input  wire logic [31:0] dir_x,
    input  wire logic [31:0] dir_y,
    input  wire logic [31:0] dir_z,
    input  wire logic [31:0] up_x,
    input  wire logic [31:0] up_y,
    input  wire logic [31:0] up_z,
    output logic             valid,
    output logic [1:0]       row_index,
    output logic [31:0]      col_first,
    output logic [31:0]      col_second,
    output logic [31:0]      col_third,
    output logic             degenerate,
    output logic             last_row
);

    logic                 pop;
    logic                 q_valid;
    lavm_pkg::item_t      item;
    logic                 norm_start;
    logic [2:0][63:0]     norm_vin;
    logic [2:0][17:0]     norm_vout;
    lavm_pkg::norm_stat_t norm_stat;

    lavm_front #(
        .DEPTH (QDEPTH)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .pos_x   (pos_x),
        .pos_y   (pos_y),
        .pos_z   (pos_z),
        .dir_x   (dir_x),
        .dir_y   (dir_y),
        .dir_z   (dir_z),
        .up_x    (up_x),
        .up_y    (up_y),
        .up_z    (up_z),
        .pop     (pop),
        .q_valid (q_valid),
        .item    (item)
    );

    lavm_norm u_norm (
        .clk   (clk),
        .rst_n (rst_n),
        .start (norm_start),
        .vin   (norm_vin),
        .vout  (norm_vout),
        .stat  (norm_stat)
    );

    lavm_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .item       (item),
        .pop        (pop),
        .norm_start (norm_start),
        .norm_vin   (norm_vin),
        .norm_vout  (norm_vout),
        .norm_stat  (norm_stat),
        .valid      (valid),
        .row_index  (row_index),
        .col_first  (col_first),
        .col_second (col_second),
        .col_third  (col_third),
        .degenerate (degenerate),
        .last_row   (last_row)
    );

endmodule

`default_nettype wire
